>>> rtl/core/ess_pkg.sv
package ess_pkg;

  localparam int unsigned CpWidth    = 21;
  localparam int unsigned BcWidth    = 3;
  localparam int unsigned TypeWidth  = 3;
  localparam int unsigned BytesWidth = 16;
  localparam int unsigned InDataW    = 32;
  localparam int unsigned InUserW    = 2;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned OutUserW   = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CpWidth-1:0] CpVs16   = 21'h00FE0F;
  localparam logic [CpWidth-1:0] CpKeycap = 21'h0020E3;
  localparam logic [CpWidth-1:0] CpRiLo   = 21'h01F1E6;
  localparam logic [CpWidth-1:0] CpRiHi   = 21'h01F1FF;
  localparam logic [CpWidth-1:0] CpZwj    = 21'h00200D;
  localparam logic [CpWidth-1:0] CpTagLo  = 21'h0E0020;
  localparam logic [CpWidth-1:0] CpTagHi  = 21'h0E007E;
  localparam logic [CpWidth-1:0] CpTagEnd = 21'h0E007F;
  localparam logic [CpWidth-1:0] CpDigit0 = 21'h000030;
  localparam logic [CpWidth-1:0] CpDigit9 = 21'h000039;
  localparam logic [CpWidth-1:0] CpHash   = 21'h000023;
  localparam logic [CpWidth-1:0] CpStar   = 21'h00002A;

  // classified item, property flags already masked by a good decode
  typedef struct packed {
    logic               start;
    logic [BcWidth-1:0] bc;
    logic               emoji;
    logic               pres;
    logic               pict;
    logic               mbase;
    logic               modif;
    logic               vs16;
    logic               keycap;
    logic               zwj;
    logic               tag;
    logic               tag_end;
    logic               ri;
    logic               kc_base;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

>>> rtl/core/ess_front.sv
module ess_front
  import ess_pkg::*;
(
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  input  queue_stat_t         qstat_i,
  output logic                push_o,
  output item_t               item_o
);

  logic [CpWidth-1:0] cp;
  logic               ok;
  logic               no_more;

  assign cp      = s_axis_tdata_i[20:0];
  assign no_more = s_axis_tuser_i[1];
  assign ok      = !no_more && s_axis_tdata_i[21];

  always_comb begin
    item_o.start   = s_axis_tuser_i[0];
    item_o.bc      = s_axis_tdata_i[24:22];
    item_o.emoji   = ok && s_axis_tdata_i[25];
    item_o.pres    = ok && s_axis_tdata_i[26];
    item_o.pict    = ok && s_axis_tdata_i[27];
    item_o.mbase   = ok && s_axis_tdata_i[28];
    item_o.modif   = ok && s_axis_tdata_i[29];
    item_o.vs16    = ok && (cp == CpVs16);
    item_o.keycap  = ok && (cp == CpKeycap);
    item_o.zwj     = ok && (cp == CpZwj);
    item_o.tag     = ok && (cp >= CpTagLo) && (cp <= CpTagHi);
    item_o.tag_end = ok && (cp == CpTagEnd);
    item_o.ri      = ok && (cp >= CpRiLo) && (cp <= CpRiHi);
    // only used on a lead that already passed the property check
    item_o.kc_base = ((cp >= CpDigit0) && (cp <= CpDigit9)) || (cp == CpHash) || (cp == CpStar);
  end

  assign s_axis_tready_o = !qstat_i.full;
  assign push_o          = s_axis_tvalid_i && !qstat_i.full;

endmodule

>>> rtl/core/ess_queue.sv
module ess_queue
  import ess_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  item_t       item_i,
  input  logic        pop_i,
  output item_t       item_o,
  output queue_stat_t qstat_o
);

  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW  = $clog2(QueueDepth + 1);

  item_t             mem_q [QueueDepth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign qstat_o.empty = (cnt_q == '0);

endmodule

>>> rtl/core/ess_back.sv
module ess_back
  import ess_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  queue_stat_t          qstat_i,
  input  item_t                item_i,
  output logic                 pop_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  output logic [OutUserW-1:0]  m_axis_tuser_o
);

  typedef enum logic [3:0] {
    PhIdle  = 4'd0,
    PhVs16  = 4'd1,
    PhKey   = 4'd2,
    PhKey2  = 4'd3,
    PhMod   = 4'd4,
    PhFlag  = 4'd5,
    PhChain = 4'd6,
    PhZwj   = 4'd7,
    PhZvs   = 4'd8,
    PhZmod  = 4'd9,
    PhTag   = 4'd10
  } phase_e;

  localparam logic [TypeWidth-1:0] TyNone    = 3'd0;
  localparam logic [TypeWidth-1:0] TyBasic   = 3'd1;
  localparam logic [TypeWidth-1:0] TyPresent = 3'd2;
  localparam logic [TypeWidth-1:0] TyKeycap  = 3'd3;
  localparam logic [TypeWidth-1:0] TyModif   = 3'd4;
  localparam logic [TypeWidth-1:0] TyFlag    = 3'd5;
  localparam logic [TypeWidth-1:0] TyTag     = 3'd6;
  localparam logic [TypeWidth-1:0] TyZwj     = 3'd7;

  phase_e                  phase_q, phase_d;
  logic                    active_q, active_d;
  logic                    kc_q, kc_d;
  logic                    mb_q, mb_d;
  logic                    ri_q, ri_d;
  logic [TypeWidth-1:0]    type_q, type_d;
  logic [BytesWidth-1:0]   bytes_q, bytes_d;
  logic [BcWidth-1:0]      pend_q, pend_d;
  logic                    zwj_q, zwj_d;
  logic                    pmod_q, pmod_d;

  logic                    out_valid_q;
  logic [TypeWidth-1:0]    out_type_q, out_type_d;
  logic [BytesWidth-1:0]   out_bytes_q, out_bytes_d;
  logic                    emit;
  logic                    done;
  logic                    fin;

  function automatic logic [BytesWidth-1:0] sat_add(logic [BytesWidth-1:0] a,
                                                    logic [BcWidth-1:0] b);
    logic [BytesWidth:0] s;
    s = {1'b0, a} + (BytesWidth + 1)'(b);
    return s[BytesWidth] ? '1 : s[BytesWidth-1:0];
  endfunction

  assign pop_o = !qstat_i.empty && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    phase_d     = phase_q;
    active_d    = active_q;
    kc_d        = kc_q;
    mb_d        = mb_q;
    ri_d        = ri_q;
    type_d      = type_q;
    bytes_d     = bytes_q;
    pend_d      = pend_q;
    zwj_d       = zwj_q;
    pmod_d      = pmod_q;
    emit        = 1'b0;
    done        = 1'b0;
    fin         = 1'b0;
    out_type_d  = TyNone;
    out_bytes_d = '0;

    if (pop_o) begin
      if (item_i.start) begin
        kc_d   = 1'b0;
        mb_d   = 1'b0;
        ri_d   = 1'b0;
        type_d = TyNone;
        pend_d = '0;
        zwj_d  = 1'b0;
        pmod_d = 1'b0;
        if (!item_i.emoji && !item_i.pict) begin
          active_d = 1'b0;
          phase_d  = PhIdle;
          bytes_d  = '0;
          emit     = 1'b1;
        end else begin
          active_d = 1'b1;
          phase_d  = PhVs16;
          kc_d     = item_i.kc_base;
          mb_d     = item_i.mbase;
          ri_d     = item_i.emoji && item_i.ri;
          type_d   = item_i.pres ? TyPresent : TyBasic;
          bytes_d  = BytesWidth'(item_i.bc);
        end
      end else if (active_q) begin
        // phases fall through in this order when a lookahead fails
        if (!done && phase_d == PhVs16) begin
          phase_d = PhKey;
          if (item_i.vs16) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyPresent;
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhKey) begin
          phase_d = PhMod;
          if (kc_q && item_i.keycap) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyKeycap;
            done    = 1'b1;
          end else if (kc_q && item_i.vs16) begin
            pend_d  = item_i.bc;
            pmod_d  = item_i.modif;
            phase_d = PhKey2;
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhKey2) begin
          bytes_d = sat_add(bytes_d, pend_q);
          pend_d  = '0;
          if (item_i.keycap) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyKeycap;
            phase_d = PhMod;
            done    = 1'b1;
          end else begin
            if (mb_q && pmod_q) begin
              type_d = TyModif;
            end
            phase_d = PhChain;
          end
        end
        if (!done && phase_d == PhMod) begin
          phase_d = PhFlag;
          if (mb_q && item_i.modif) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyModif;
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhFlag) begin
          phase_d = PhChain;
          if (ri_q && item_i.ri) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyFlag;
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhZvs) begin
          phase_d = PhZmod;
          if (item_i.vs16) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhZmod) begin
          phase_d = PhChain;
          if (item_i.modif) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            done    = 1'b1;
          end
        end
        if (!done && phase_d == PhChain) begin
          done = 1'b1;
          if (item_i.zwj) begin
            pend_d  = item_i.bc;
            phase_d = PhZwj;
          end else if (item_i.vs16) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
          end else if (item_i.tag) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            phase_d = PhTag;
          end else begin
            fin = 1'b1;
          end
        end
        if (!done && phase_d == PhZwj) begin
          done = 1'b1;
          // a zwj only counts once an emoji follows it
          if (item_i.emoji || item_i.pict) begin
            bytes_d = sat_add(sat_add(bytes_d, pend_q), item_i.bc);
            pend_d  = '0;
            zwj_d   = 1'b1;
            phase_d = PhZvs;
          end else begin
            pend_d = '0;
            fin    = 1'b1;
          end
        end
        if (!done && phase_d == PhTag) begin
          done = 1'b1;
          if (item_i.tag_end) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
            type_d  = TyTag;
            fin     = 1'b1;
          end else if (item_i.tag) begin
            bytes_d = sat_add(bytes_d, item_i.bc);
          end else begin
            fin = 1'b1;
          end
        end
        if (!done) begin
          fin = 1'b1;
        end
        if (fin) begin
          emit        = 1'b1;
          out_type_d  = zwj_d ? TyZwj : type_d;
          out_bytes_d = bytes_d;
          active_d    = 1'b0;
          phase_d     = PhIdle;
          pend_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      active_q    <= 1'b0;
      kc_q        <= 1'b0;
      mb_q        <= 1'b0;
      ri_q        <= 1'b0;
      type_q      <= TyNone;
      bytes_q     <= '0;
      pend_q      <= '0;
      zwj_q       <= 1'b0;
      pmod_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_type_q  <= TyNone;
      out_bytes_q <= '0;
    end else begin
      phase_q  <= phase_d;
      active_q <= active_d;
      kc_q     <= kc_d;
      mb_q     <= mb_d;
      ri_q     <= ri_d;
      type_q   <= type_d;
      bytes_q  <= bytes_d;
      pend_q   <= pend_d;
      zwj_q    <= zwj_d;
      pmod_q   <= pmod_d;
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
        out_type_q  <= out_type_d;
        out_bytes_q <= out_bytes_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_bytes_q;
  assign m_axis_tuser_o  = out_type_q;

endmodule

>>> rtl/core/emoji_sequence_scanner_top.sv
// channel  dir  tdata, low bit up                              tuser, low bit up
// s_axis   in   code_point, decode_ok, byte_count, prop flags  start_scan, no_more_data
// m_axis   out  used_bytes                                     seq_type
//
// one item per cycle sustained while m_axis takes results; the back end handles each item as it pops it
// a result passes the queue write and then the result register, loaded when the back end pops the item that ends it
// reset clears the queue pointers, the scan state and the result register
// a waiting result holds the back end; the two-entry queue fills up, then tready drops
module emoji_sequence_scanner_top
  import ess_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // code_point[20:0], decode_ok[21], byte_count[24:22], prop_emoji[25],
  // prop_presentation[26], prop_pictographic[27], prop_modifier_base[28],
  // prop_modifier[29], zero[31:30]
  input  logic [InDataW-1:0]   s_axis_tdata_i,
  // start_scan[0], no_more_data[1]
  input  logic [InUserW-1:0]   s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // used_bytes[15:0]
  output logic [OutDataW-1:0]  m_axis_tdata_o,
  // seq_type[2:0]
  output logic [OutUserW-1:0]  m_axis_tuser_o
);

  queue_stat_t qstat;
  item_t       push_item;
  item_t       head_item;
  logic        push;
  logic        pop;

  ess_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .item_o          (push_item)
  );

  ess_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .qstat_o (qstat)
  );

  ess_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .qstat_i         (qstat),
    .item_i          (head_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
